// ----- rtl/fpll_pkg.sv -----
// Shared types and constants of the four-pole ladder low-pass filter.
// No dependencies; used by fpll_mul, fpll_core and four_pole_ladder_lowpass.
package fpll_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 15;
    localparam int WORD_W     = 32;
    localparam int WIDEN_SH   = 14;
    localparam int FB_SH      = 3;
    localparam int DIGIT_W    = 4;
    localparam int MUL_DIGITS = 4;
    localparam int COEF_SR_W  = DIGIT_W * MUL_DIGITS;
    localparam int ACC_W      = WORD_W + DIGIT_W + 1;
    localparam int DIG_CNT_W  = $clog2(MUL_DIGITS);
    localparam int REG_IDX_W  = 1;

    localparam logic [REG_IDX_W-1:0] REG_CUTOFF    = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_RESONANCE = 1'd1;

    localparam logic [COEF_W-1:0] CUTOFF_RST    = 15'd2048;
    localparam logic [COEF_W-1:0] RESONANCE_RST = 15'd0;

    localparam logic [DIG_CNT_W-1:0] DIG_LAST = DIG_CNT_W'(MUL_DIGITS - 1);

    typedef enum logic [2:0] {
        OP_FEEDBACK = 3'd0,
        OP_POLE1    = 3'd1,
        OP_POLE2    = 3'd2,
        OP_POLE3    = 3'd3,
        OP_POLE4    = 3'd4
    } t_op;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LOAD = 5'b00010,
        S_MUL  = 5'b00100,
        S_FIN  = 5'b01000,
        S_PUSH = 5'b10000
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_mul_ctl;

    typedef struct packed {
        logic idle;
        logic push;
    } t_core_stat;

endpackage

// ----- rtl/fpll_mul.sv -----
// Digit-serial signed multiplier: 32-bit word times 15-bit coefficient, one 4-bit digit a cycle while stepping.
// Returns (word * coef) >>> 16, the high word of word * (coef << 16). Depends on fpll_pkg.
module fpll_mul (
    input  logic                                i_clk,
    input  fpll_pkg::t_mul_ctl                  i_ctl,
    input  logic [fpll_pkg::WORD_W-1:0]         i_mcand,
    input  logic [fpll_pkg::COEF_W-1:0]         i_coef,
    output logic [fpll_pkg::WORD_W-1:0]         o_prod
);

    logic        [fpll_pkg::WORD_W-1:0]    r_mcand;
    logic        [fpll_pkg::COEF_SR_W-1:0] r_coef;
    logic signed [fpll_pkg::ACC_W-1:0]     r_acc;
    logic signed [fpll_pkg::ACC_W-1:0]     n_acc;

    logic signed [fpll_pkg::ACC_W:0]       w_mc_ext;
    logic signed [fpll_pkg::ACC_W:0]       w_dig_ext;
    logic signed [fpll_pkg::ACC_W:0]       w_pp;
    logic signed [fpll_pkg::ACC_W:0]       w_sum;

    always_comb begin
        w_mc_ext  = {{(fpll_pkg::ACC_W + 1 - fpll_pkg::WORD_W){r_mcand[fpll_pkg::WORD_W-1]}},
                     r_mcand};
        w_dig_ext = {{(fpll_pkg::ACC_W + 1 - fpll_pkg::DIGIT_W){1'b0}},
                     r_coef[fpll_pkg::DIGIT_W-1:0]};
        w_pp      = w_mc_ext * w_dig_ext;
        w_sum     = {r_acc[fpll_pkg::ACC_W-1], r_acc} + w_pp;
        n_acc     = fpll_pkg::ACC_W'(w_sum >>> fpll_pkg::DIGIT_W);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_mcand <= i_mcand;
            r_coef  <= fpll_pkg::COEF_SR_W'(i_coef);
            r_acc   <= '0;
        end else if (i_ctl.step) begin
            r_coef  <= r_coef >> fpll_pkg::DIGIT_W;
            r_acc   <= n_acc;
        end
    end

    assign o_prod = r_acc[fpll_pkg::WORD_W-1:0];

endmodule

// ----- rtl/fpll_core.sv -----
// Sequencer and state of the ladder: feedback, then four one-pole updates, all on one
// shared digit-serial multiplier. Depends on fpll_pkg and fpll_mul.
module fpll_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [fpll_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic [fpll_pkg::COEF_W-1:0]     i_cutoff,
    input  logic [fpll_pkg::COEF_W-1:0]     i_resonance,
    input  logic                            i_out_free,
    output fpll_pkg::t_core_stat            o_stat,
    output logic [fpll_pkg::WORD_W-1:0]     o_pole4
);

    fpll_pkg::t_state                   r_state;
    fpll_pkg::t_op                      r_op;
    logic [fpll_pkg::DIG_CNT_W-1:0]     r_dig;
    logic [fpll_pkg::WORD_W-1:0]        r_v;
    logic [fpll_pkg::WORD_W-1:0]        r_pole1;
    logic [fpll_pkg::WORD_W-1:0]        r_pole2;
    logic [fpll_pkg::WORD_W-1:0]        r_pole3;
    logic [fpll_pkg::WORD_W-1:0]        r_pole4;

    fpll_pkg::t_mul_ctl                 w_ctl;
    logic [fpll_pkg::WORD_W-1:0]        w_mcand;
    logic [fpll_pkg::COEF_W-1:0]        w_coef;
    logic [fpll_pkg::WORD_W-1:0]        w_prod;

    fpll_mul u_mul (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_mcand (w_mcand),
        .i_coef  (w_coef),
        .o_prod  (w_prod)
    );

    always_comb begin
        w_ctl.load = (r_state == fpll_pkg::S_LOAD);
        w_ctl.step = (r_state == fpll_pkg::S_MUL);
        w_coef     = i_cutoff;
        case (r_op)
            fpll_pkg::OP_FEEDBACK: begin
                w_mcand = r_pole4 - r_v;
                w_coef  = i_resonance;
            end
            fpll_pkg::OP_POLE1: w_mcand = r_v - r_pole1;
            fpll_pkg::OP_POLE2: w_mcand = r_pole1 - r_pole2;
            fpll_pkg::OP_POLE3: w_mcand = r_pole2 - r_pole3;
            fpll_pkg::OP_POLE4: w_mcand = r_pole3 - r_pole4;
            default:            w_mcand = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fpll_pkg::S_IDLE;
            r_op    <= fpll_pkg::OP_FEEDBACK;
            r_dig   <= '0;
            r_pole1 <= '0;
            r_pole2 <= '0;
            r_pole3 <= '0;
            r_pole4 <= '0;
        end else begin
            case (r_state)
                fpll_pkg::S_IDLE: begin
                    if (i_start) begin
                        r_v     <= {{(fpll_pkg::WORD_W - fpll_pkg::SAMPLE_W - fpll_pkg::WIDEN_SH)
                                     {i_sample[fpll_pkg::SAMPLE_W-1]}},
                                    i_sample, {fpll_pkg::WIDEN_SH{1'b0}}};
                        r_op    <= fpll_pkg::OP_FEEDBACK;
                        r_state <= fpll_pkg::S_LOAD;
                    end
                end
                fpll_pkg::S_LOAD: begin
                    r_dig   <= '0;
                    r_state <= fpll_pkg::S_MUL;
                end
                fpll_pkg::S_MUL: begin
                    r_dig <= r_dig + 1'b1;
                    if (r_dig == fpll_pkg::DIG_LAST) begin
                        r_state <= fpll_pkg::S_FIN;
                    end
                end
                fpll_pkg::S_FIN: begin
                    case (r_op)
                        fpll_pkg::OP_FEEDBACK: r_v     <= r_v - (w_prod << fpll_pkg::FB_SH);
                        fpll_pkg::OP_POLE1:    r_pole1 <= r_pole1 + w_prod;
                        fpll_pkg::OP_POLE2:    r_pole2 <= r_pole2 + w_prod;
                        fpll_pkg::OP_POLE3:    r_pole3 <= r_pole3 + w_prod;
                        fpll_pkg::OP_POLE4:    r_pole4 <= r_pole4 + w_prod;
                        default:               r_v     <= r_v;
                    endcase
                    if (r_op == fpll_pkg::OP_POLE4) begin
                        r_state <= fpll_pkg::S_PUSH;
                    end else begin
                        r_op    <= fpll_pkg::t_op'(r_op + 3'd1);
                        r_state <= fpll_pkg::S_LOAD;
                    end
                end
                fpll_pkg::S_PUSH: begin
                    if (i_out_free) begin
                        r_state <= fpll_pkg::S_IDLE;
                    end
                end
                default: r_state <= fpll_pkg::S_IDLE;
            endcase
        end
    end

    assign o_stat.idle = (r_state == fpll_pkg::S_IDLE);
    assign o_stat.push = (r_state == fpll_pkg::S_PUSH) && i_out_free;
    assign o_pole4     = r_pole4;

endmodule

// ----- rtl/four_pole_ladder_lowpass.sv -----
// Top level of the four-pole resonant ladder low-pass filter: handshakes, coefficient
// registers, output saturation and output register. Depends on fpll_pkg and fpll_core.
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+--------------------------------
//   input    | in        | i_in_valid / o_in_stall   | i_sample_in  (s16)
//   output   | out       | o_out_valid / i_out_stall | o_sample_out (s16)
//   config   | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data (u15)
//
// o_out_valid rises once the accepted input beat is through the core: five multiplies (feedback
// and four poles) share one 4-bit-digit serial multiplier, each via load, multiply and finish, plus one push.
// A new beat is accepted only once the previous result is pushed and the core is idle again.
// Synchronous active-low reset clears the poles and sets cutoff 2048, resonance 0.
// A stalled output holds its beat; the core waits before overwriting it.
module four_pole_ladder_lowpass (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [fpll_pkg::SAMPLE_W-1:0] i_sample_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [fpll_pkg::SAMPLE_W-1:0] o_sample_out,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [fpll_pkg::REG_IDX_W-1:0]      i_cfg_index,
    input  logic [fpll_pkg::COEF_W-1:0]         i_cfg_data
);

    logic [fpll_pkg::COEF_W-1:0]    r_cutoff;
    logic [fpll_pkg::COEF_W-1:0]    r_resonance;
    logic                           r_out_valid;
    logic [fpll_pkg::SAMPLE_W-1:0]  r_out_data;
    logic [fpll_pkg::SAMPLE_W-1:0]  n_out_data;

    fpll_pkg::t_core_stat           w_stat;
    logic [fpll_pkg::WORD_W-1:0]    w_pole4;
    logic                           w_out_free;
    logic                           w_start;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_start    = i_in_valid && w_stat.idle;
    assign o_in_stall = !w_stat.idle;
    assign o_cfg_ready = 1'b1;

    fpll_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_sample    (i_sample_in),
        .i_cutoff    (r_cutoff),
        .i_resonance (r_resonance),
        .i_out_free  (w_out_free),
        .o_stat      (w_stat),
        .o_pole4     (w_pole4)
    );

    // pole4 >>> 14 fits 16 bits when bits 31..29 agree
    always_comb begin
        if ((w_pole4[31:29] == 3'b000) || (w_pole4[31:29] == 3'b111)) begin
            n_out_data = w_pole4[29:14];
        end else if (w_pole4[31]) begin
            n_out_data = {1'b1, {(fpll_pkg::SAMPLE_W - 1){1'b0}}};
        end else begin
            n_out_data = {1'b0, {(fpll_pkg::SAMPLE_W - 1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff    <= fpll_pkg::CUTOFF_RST;
            r_resonance <= fpll_pkg::RESONANCE_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    fpll_pkg::REG_CUTOFF:    r_cutoff    <= i_cfg_data;
                    fpll_pkg::REG_RESONANCE: r_resonance <= i_cfg_data;
                    default:                 r_cutoff    <= r_cutoff;
                endcase
            end
            if (w_stat.push) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_stat.push) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out_data;

endmodule

// ----- dv/four_pole_ladder_lowpass_checker.sv -----
// Checker for four_pole_ladder_lowpass: tracks coefficient writes, predicts each
// output sample from the accepted input beats and compares in order.
// Depends on fpll_pkg for widths, register indexes and reset coefficients.
module four_pole_ladder_lowpass_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    input  logic                                 i_in_stall,
    input  logic signed [fpll_pkg::SAMPLE_W-1:0] i_sample_in,
    input  logic                                 i_out_valid,
    input  logic                                 i_out_stall,
    input  logic signed [fpll_pkg::SAMPLE_W-1:0] i_sample_out,
    input  logic                                 i_cfg_valid,
    input  logic                                 i_cfg_ready,
    input  logic [fpll_pkg::REG_IDX_W-1:0]       i_cfg_index,
    input  logic [fpll_pkg::COEF_W-1:0]          i_cfg_data,
    output int                                   o_errors,
    output int                                   o_pending,
    output int                                   o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import fpll_pkg::*;

    logic [COEF_W-1:0]          cutoff_q;
    logic [COEF_W-1:0]          resonance_q;
    logic [WORD_W-1:0]          pole_q [4];
    logic signed [SAMPLE_W-1:0] expected_samples [$];

    function automatic logic [WORD_W-1:0] product_high(input logic [WORD_W-1:0] a,
                                                       input logic [WORD_W-1:0] b);
        logic signed [2*WORD_W-1:0] sa;
        logic signed [2*WORD_W-1:0] sb;
        logic signed [2*WORD_W-1:0] prod;
        sa   = $signed(a);
        sb   = $signed(b);
        prod = sa * sb;
        return prod[2*WORD_W-1:WORD_W];
    endfunction

    // Advances the four poles by one sample and returns the saturated output.
    function automatic logic signed [SAMPLE_W-1:0] filter_sample(
        input logic signed [SAMPLE_W-1:0] s);
        logic [WORD_W-1:0]        gain;
        logic [WORD_W-1:0]        fb;
        logic [WORD_W-1:0]        drive;
        logic signed [WORD_W-1:0] out_wide;
        gain  = {1'b0, cutoff_q, 16'd0};
        fb    = {1'b0, resonance_q, 16'd0};
        drive = {{(WORD_W-SAMPLE_W){s[SAMPLE_W-1]}}, s} << WIDEN_SH;
        drive = drive - (product_high(pole_q[3] - drive, fb) << FB_SH);
        for (int i = 0; i < 4; i++) begin
            pole_q[i] = pole_q[i] + product_high(drive - pole_q[i], gain);
            drive     = pole_q[i];
        end
        out_wide = $signed(pole_q[3]) >>> WIDEN_SH;
        if (out_wide > 32767) begin
            return 16'sh7FFF;
        end else if (out_wide < -32768) begin
            return 16'sh8000;
        end
        return out_wide[SAMPLE_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        logic signed [SAMPLE_W-1:0] want;
        if (!i_rst_n) begin
            cutoff_q    = CUTOFF_RST;
            resonance_q = RESONANCE_RST;
            for (int i = 0; i < 4; i++) begin
                pole_q[i] = '0;
            end
            expected_samples.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_CUTOFF:    cutoff_q = i_cfg_data;
                    REG_RESONANCE: resonance_q = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                expected_samples.push_back(filter_sample(i_sample_in));
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_samples.size() == 0) begin
                    $display("%0t: unexpected sample_out %0d, expected none",
                             $time, i_sample_out);
                    o_errors++;
                end else begin
                    want = expected_samples.pop_front();
                    o_checked++;
                    if (i_sample_out !== want) begin
                        $display("%0t: sample_out mismatch, expected %0d, got %0d",
                                 $time, want, i_sample_out);
                        o_errors++;
                    end
                end
            end
        end
        o_pending = expected_samples.size();
    end

endmodule

// ----- dv/four_pole_ladder_lowpass_test.sv -----
// Top of the four_pole_ladder_lowpass testbench: clock, reset, coefficient writes,
// sample and output-stall stimulus, verdict. Depends on fpll_pkg, the block and
// four_pole_ladder_lowpass_checker.
module four_pole_ladder_lowpass_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fpll_pkg::*;

    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 47;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE_CYCLES = 40;

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_in_valid  = 1'b0;
    logic signed [SAMPLE_W-1:0] i_sample_in = '0;
    logic                       i_out_stall = 1'b0;
    logic                       i_cfg_valid = 1'b0;
    logic [REG_IDX_W-1:0]       i_cfg_index = '0;
    logic [COEF_W-1:0]          i_cfg_data  = '0;
    logic                       o_in_stall;
    logic                       o_out_valid;
    logic signed [SAMPLE_W-1:0] o_sample_out;
    logic                       o_cfg_ready;

    int errors;
    int pending;
    int checked;
    int samples_sent;
    int settings_used;
    int hold_requests;
    int holds_done;
    bit gaps_on;
    bit stalls_on;

    logic signed [SAMPLE_W-1:0] warmup_samples [12] = '{
        16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000,
        16'sh8000, 16'sh8000, 16'sh0000, 16'sh0001, 16'shFFFF, 16'sh5555
    };
    int cutoff_plan [NUM_PHASES]    = '{0, 32767, 16384, -1, 1, -1, 2048, 32767};
    int resonance_plan [NUM_PHASES] = '{32767, 0, 32767, -1, 0, -1, 16384, 30000};

    four_pole_ladder_lowpass u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_sample_in  (i_sample_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_sample_out (o_sample_out),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    four_pole_ladder_lowpass_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_sample_in  (i_sample_in),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_sample_out (o_sample_out),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always #10 i_clk = ~i_clk;

    // Mostly short idle runs, now and then a long one.
    function automatic int pick_idle_len();
        int r;
        r = $urandom_range(99);
        if (r < 80) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample(
        input logic signed [SAMPLE_W-1:0] prev);
        int r;
        r = $urandom_range(9);
        if (r < 5) begin
            return SAMPLE_W'($urandom);
        end else if (r < 7) begin
            return SAMPLE_W'(int'($urandom_range(512)) - 256);
        end else if (r < 8) begin
            return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        end
        return prev;
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
        if (gaps_on && $urandom_range(99) < 45) begin
            i_in_valid = 1'b0;
            repeat (pick_idle_len()) @(negedge i_clk);
        end
        i_sample_in = s;
        i_in_valid  = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        samples_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
        i_cfg_index = idx;
        i_cfg_data  = val;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // Output side: random stalls, plus a long hold-off whenever one is requested.
    always begin
        @(negedge i_clk);
        if (hold_requests != holds_done) begin
            i_out_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge i_clk);
            i_out_stall = 1'b0;
            holds_done++;
        end else if (stalls_on && $urandom_range(99) < 25) begin
            i_out_stall = 1'b1;
            repeat (pick_idle_len()) @(negedge i_clk);
            i_out_stall = 1'b0;
        end else begin
            i_out_stall = 1'b0;
        end
    end

    initial begin
        logic signed [SAMPLE_W-1:0] s;
        logic [COEF_W-1:0]          cut;
        logic [COEF_W-1:0]          res;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset coefficients, full-scale steps and tiny values.
        foreach (warmup_samples[i]) begin
            send_sample(warmup_samples[i]);
        end
        wait_drained();

        // Both coefficients at full scale: wrapping sums and output saturation.
        write_reg(REG_CUTOFF, '1);
        write_reg(REG_RESONANCE, '1);
        settings_used = 2;
        for (int i = 0; i < 12; i++) begin
            send_sample((i % 2 == 0) ? 16'sh7FFF : 16'sh8000);
        end
        wait_drained();

        s = '0;
        for (int p = 0; p < NUM_PHASES; p++) begin
            repeat (SETTLE_CYCLES) @(negedge i_clk);
            cut = (cutoff_plan[p] < 0) ? COEF_W'($urandom_range(32767)) :
                                         COEF_W'(cutoff_plan[p]);
            res = (resonance_plan[p] < 0) ? COEF_W'($urandom_range(32767)) :
                                            COEF_W'(resonance_plan[p]);
            if ($urandom_range(1)) begin
                write_reg(REG_CUTOFF, cut);
                write_reg(REG_RESONANCE, res);
            end else begin
                write_reg(REG_RESONANCE, res);
                write_reg(REG_CUTOFF, cut);
            end
            settings_used++;
            gaps_on   = (p % 4 != 3) && (p != 5);
            stalls_on = (p % 4 != 2) && (p != 5);
            if (p == 1) begin
                hold_requests++;
            end
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == 3 && i == 20) begin
                    wait_drained();
                    repeat (pick_idle_len()) @(negedge i_clk);
                end
                s = pick_sample(s);
                send_sample(s);
            end
            wait_drained();
        end

        stalls_on = 1'b0;
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        $display("Sent %0d samples over %0d coefficient settings, %0d results checked,",
                 samples_sent, settings_used, checked);
        $display("with full-scale coefficients, output hold-off and input backpressure.");
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/fpll_pkg.sv
rtl/fpll_mul.sv
rtl/fpll_core.sv
rtl/four_pole_ladder_lowpass.sv
dv/four_pole_ladder_lowpass_checker.sv
dv/four_pole_ladder_lowpass_test.sv
